@@ rtl/linear_probe_hash_set_top_macros.svh @@
// assertion macros for the hash set rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef LINEAR_PROBE_HASH_SET_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_TOP_MACROS_SVH

// property that must hold at every edge out of reset
`define LPHS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define LPHS_ASSERT_IMPLIES(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define LPHS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/lphs_pkg.sv @@
// types and constants for the linear probing hash set
// used by the front, queue, back and top level; depends on nothing
package lphs_pkg;

	// key and hash
	localparam int unsigned KEY_W = 64;
	localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned MIX_SHIFT = 33;

	// home slot carried at its widest supported size, cut down in the back
	localparam int unsigned HOME_W = 16;

	// slot word: used mark above the key
	localparam int unsigned SLOT_W = KEY_W + 1;

	localparam int unsigned KEY_COUNT_W = 10;
	localparam int unsigned QUEUE_DEPTH = 2;

	// request kinds
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_PUSH
	} lphs_fstate_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE,
		B_EMIT
	} lphs_bstate_t;

	typedef struct packed {
		logic req_type;
		logic [KEY_W-1:0] key_value;
		logic [HOME_W-1:0] home;
	} lphs_entry_t;

	typedef struct packed {
		logic found;
		logic inserted;
		logic refused_full;
		logic [KEY_COUNT_W-1:0] key_count;
	} lphs_result_t;

endpackage

@@ rtl/linear_probe_hash_set_top.sv @@
// linear probing hash set of 64-bit keys
// the front hashes one request at a time with the 8-step fmix64 multiply, then pushes it
// the back handles one request at a time, bounded by one table read per probed slot
// after reset the table is cleared with s_tready held low
// depends on lphs_pkg, lphs_front, lphs_queue, lphs_back and lphs_ram
module linear_probe_hash_set_top #(
	parameter int unsigned TABLE_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic signed [63:0] s_tdata,  // [63:0] key_value
	input  logic [0:0]         s_tuser,  // [0] req_type
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,  // [9:0] key_count, [15:10] zero
	output logic [2:0]         m_tuser   // [0] found, [1] inserted, [2] refused_full
);
	import lphs_pkg::*;

	logic         clearing;
	logic         push;
	logic         q_full;
	logic         q_pop;
	logic         q_empty;
	lphs_entry_t  push_entry;
	lphs_entry_t  pop_entry;
	lphs_result_t result;

	// request intake and hashing
	lphs_front #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (clearing),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser[0]),
		.in_key    ($unsigned(s_tdata)),
		.push      (push),
		.push_entry(push_entry),
		.q_full    (q_full)
	);

	// decoupling queue
	lphs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_entry (pop_entry),
		.empty     (q_empty)
	);

	// probe engine and result register
	lphs_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_empty   (q_empty),
		.q_entry   (pop_entry),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_result(result)
	);

	assign m_tdata = 16'(result.key_count);
	assign m_tuser = {result.refused_full, result.inserted, result.found};

endmodule

@@ rtl/lphs_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lphs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lphs_front.sv @@
// front end: takes requests, works out the fmix64 home slot, hands to the queue
// depends on lphs_pkg
module lphs_front #(
	parameter int unsigned TABLE_SLOTS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hold,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_req,
	input  logic [63:0]         in_key,
	output logic                push,
	output lphs_pkg::lphs_entry_t push_entry,
	input  logic                q_full
);
	import lphs_pkg::*;

	localparam logic [HOME_W-1:0] HOME_MASK = HOME_W'(TABLE_SLOTS - 1);

	// phase within one 64x64 multiply; each product is accumulated in the phase after its issue
	localparam logic [1:0] PH_LL   = 2'd0;
	localparam logic [1:0] PH_LH   = 2'd1;
	localparam logic [1:0] PH_HL   = 2'd2;
	localparam logic [1:0] PH_FOLD = 2'd3;
	localparam logic [2:0] STEP_LAST = 3'd7;

	lphs_fstate_t state_q, state_d;
	logic [2:0] step_q;

	logic             req_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] h_q;
	logic [KEY_W-1:0] acc_q;
	logic [KEY_W-1:0] prod_q;
	logic [HOME_W-1:0] home_q;

	logic [31:0]      op_a;
	logic [31:0]      op_b;
	logic [KEY_W-1:0] mul_c;
	logic [KEY_W-1:0] prod_d;
	logic [KEY_W-1:0] acc_sum;
	logic [KEY_W-1:0] mixed;

	// operand select: low*low, low*const_hi, high*const_lo; second constant in the upper half
	always_comb begin
		mul_c = step_q[2] ? MIX_C2 : MIX_C1;
		op_a  = (step_q[1:0] == PH_HL) ? h_q[63:32] : h_q[31:0];
		op_b  = (step_q[1:0] == PH_LH) ? mul_c[63:32] : mul_c[31:0];
	end

	assign prod_d  = op_a * op_b;
	assign acc_sum = acc_q + {prod_q[31:0], 32'b0};
	assign mixed   = acc_sum ^ (acc_sum >> MIX_SHIFT);

	// next state and handshakes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = !hold;
				if (in_valid && !hold) begin
					state_d = F_HASH;
				end
			end
			F_HASH: begin
				if (step_q == STEP_LAST) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push = 1'b1;
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_HASH) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// hash datapath: one 32x32 product per cycle, accumulated the cycle after
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_req;
			key_q <= in_key;
			h_q   <= in_key ^ (in_key >> MIX_SHIFT);
		end
		if (state_q == F_HASH) begin
			prod_q <= prod_d;
			case (step_q[1:0])
				PH_LH: begin
					acc_q <= prod_q;
				end
				PH_HL: begin
					acc_q <= acc_sum;
				end
				PH_FOLD: begin
					h_q    <= mixed;
					home_q <= mixed[HOME_W-1:0] & HOME_MASK;
				end
				default: begin
				end
			endcase
		end
	end

	assign push_entry = '{req_type: req_q, key_value: key_q, home: home_q};

endmodule

@@ rtl/lphs_queue.sv @@
// short fifo of classified requests between front and back
// depends on lphs_pkg
module lphs_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lphs_pkg::lphs_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output lphs_pkg::lphs_entry_t pop_entry,
	output logic                  empty
);
	import lphs_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	lphs_entry_t      entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ rtl/lphs_back.sv @@
// back end: clears the table after reset, walks probe chains, inserts, holds the result
// depends on lphs_pkg, lphs_ram and the assertion macro header
`include "linear_probe_hash_set_top_macros.svh"

module lphs_back #(
	parameter int unsigned TABLE_SLOTS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	output logic                   clearing,
	input  logic                   q_empty,
	input  lphs_pkg::lphs_entry_t  q_entry,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output lphs_pkg::lphs_result_t out_result
);
	import lphs_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
	localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(TABLE_SLOTS);

	lphs_bstate_t state_q, state_d;

	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	lphs_result_t     out_q;
	lphs_result_t     res_q;

	logic             req_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] n_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [SLOT_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;

	logic             slot_used;
	logic             slot_hit;
	logic             probe_done;
	logic             at_limit;
	logic             ins_fire;
	logic             refuse;
	logic [IDX_W-1:0] pos_next;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W:0]   cnt_dbl;
	logic             out_free;

	lphs_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// probe evaluation on the slot read last cycle
	assign slot_used  = ram_rdata[SLOT_W-1];
	assign slot_hit   = slot_used && (ram_rdata[KEY_W-1:0] == key_q);
	assign probe_done = !slot_used || slot_hit || (n_q == LAST_IDX);
	assign cnt_dbl    = {cnt_q, 1'b0};
	assign at_limit   = (cnt_dbl >= LIMIT);
	assign pos_next   = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
	assign ins_fire   = (state_q == B_PROBE) && probe_done && (req_q == REQ_ADD)
		&& !slot_used && !at_limit;
	assign refuse     = (req_q == REQ_ADD) && !slot_hit && !ins_fire;
	assign cnt_next   = cnt_q + CNT_W'(ins_fire);
	assign out_free   = !out_valid_q || out_ready;
	assign clearing   = (state_q == B_CLEAR);

	// next state, memory ports and queue pop
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {1'b1, key_q};
		ram_raddr = pos_q;
		case (state_q)
			B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == LAST_IDX) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				ram_raddr = IDX_W'(q_entry.home);
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_PROBE;
				end
			end
			B_PROBE: begin
				ram_raddr = pos_next;
				ram_we    = ins_fire;
				if (probe_done) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ins_fire) begin
				cnt_q <= cnt_next;
			end
			if (state_q == B_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_entry.req_type;
			key_q <= q_entry.key_value;
			pos_q <= IDX_W'(q_entry.home);
			n_q   <= '0;
		end
		if (state_q == B_PROBE) begin
			if (probe_done) begin
				res_q <= '{found: slot_hit, inserted: ins_fire, refused_full: refuse,
					key_count: KEY_COUNT_W'(cnt_next)};
			end else begin
				pos_q <= pos_next;
				n_q   <= n_q + 1'b1;
			end
		end
		if (state_q == B_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	// checks
	`LPHS_ASSERT_ALWAYS(a_count_limit, cnt_dbl <= LIMIT, "stored count passed half the table")
	`LPHS_ASSERT_IMPLIES(a_no_pop_clearing, state_q == B_CLEAR, !q_pop, "request taken during clear")
	`LPHS_ASSERT_IMPLIES(a_write_source, ram_we, (state_q == B_CLEAR) || ins_fire, "stray table write")
	`LPHS_ASSERT_NEXT(a_insert_counts, ins_fire, cnt_q == $past(cnt_q) + 1'b1, "insert not counted")
	`LPHS_ASSERT_IMPLIES(a_result_flags, out_valid_q, !(out_q.found && out_q.inserted) && !(out_q.inserted && out_q.refused_full), "conflicting result flags")

endmodule
